[src/kwh_pkg.sv]
// kwh_pkg: shared types and constants for the k-mer window hasher.
// Holds the base letter code table and the special character codes.
// No dependencies.
package kwh_pkg;

    // Letter lookup result: known flag plus 2-bit base code
    typedef struct packed {
        logic       known;
        logic [1:0] code;
    } base_code_t;

    // Character codes with special meaning
    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_Z = 8'h5A;
    localparam logic [7:0] CHAR_J = 8'h4A;
    localparam logic [7:0] CHAR_X = 8'h58;
    localparam logic [7:0] CHAR_N = 8'h4E;

    // Register reset value for k
    localparam logic [5:0] KMER_LENGTH_RESET = 6'd15;

    // Upper-case letter table, A..Z; bit 2 set means no code
    localparam logic [2:0] LETTER_CODE [26] = '{
        3'd0, 3'd3, 3'd1, 3'd3, 3'd4, 3'd4, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd4, 3'd0,
        3'd3, 3'd4, 3'd4, 3'd4, 3'd0, 3'd2, 3'd3, 3'd4, 3'd0, 3'd3, 3'd1, 3'd3, 3'd4
    };

    // Map an ASCII character to its base code
    function automatic base_code_t lookup_base(input logic [7:0] ch);
        base_code_t  res;
        logic [7:0]  offs;
        logic [2:0]  entry;
        res  = '0;
        offs = ch - CHAR_A;
        if (ch >= CHAR_A && ch <= CHAR_Z) begin
            entry     = LETTER_CODE[offs[4:0]];
            res.known = ~entry[2];
            res.code  = entry[1:0];
        end
        return res;
    endfunction

endpackage

[src/kmer_window_hasher.sv]
// kmer_window_hasher: rolling 2-bit k-mer key over a stream of base characters.
// Depends on kwh_pkg for the letter table and character codes.
// Key, run and position logic sit before one output register, which holds each result.
// Throughput: one base per clock while the output register is empty or being read.
// Reset (aresetn low, synchronous): key, run, position cleared, k set to 15, output empty.
module kmer_window_hasher #(
    parameter int MAX_KMER = 32
) (
    input  logic         aclk,
    input  logic         aresetn,

    // Configuration: kmer_length write
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [5:0]   cfg_data,      // kmer_length

    // Base input
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,       // [7:0] base_char
    input  logic [0:0]   s_tuser,       // [0] new_sequence

    // Result output
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,       // [31:0] window_start, [95:32] kmer_key
    output logic [0:0]   m_tuser        // [0] bad_base
);

    localparam int KEY_W = 2 * MAX_KMER;
    localparam int RUN_W = $clog2(MAX_KMER + 1);
    localparam logic [RUN_W-1:0] RUN_MAX = RUN_W'(MAX_KMER);

    // State registers
    logic [5:0]        kmer_length_reg;
    logic [KEY_W-1:0]  rolling_key_reg, rolling_key_next;
    logic [RUN_W-1:0]  usable_run_reg, usable_run_next;
    logic [31:0]       base_index_reg, base_index_next;

    // Output register
    logic              m_valid_reg, m_valid_next;
    logic [31:0]       window_start_reg, window_start_next;
    logic [63:0]       kmer_key_reg, kmer_key_next;
    logic              bad_base_reg, bad_base_next;

    // Datapath intermediates
    logic                 accept;
    logic                 fresh;
    logic [7:0]           base_char;
    kwh_pkg::base_code_t  lookup;
    logic                 restart_char;
    logic [KEY_W-1:0]     key_base;
    logic [RUN_W-1:0]     run_base;
    logic [31:0]          pos;
    logic [RUN_W-1:0]     k_eff;
    logic [6:0]           key_bits;
    logic [KEY_W-1:0]     key_mask;

    assign cfg_ready = 1'b1;
    assign s_tready  = ~m_valid_reg | m_tready;
    assign accept    = s_tvalid & s_tready;
    assign base_char = s_tdata[7:0];
    assign fresh     = s_tuser[0];

    // Effective k: zero means one, clamp at the maximum window
    always_comb begin
        if (kmer_length_reg == 6'd0) begin
            k_eff = RUN_W'(1);
        end else if (32'(kmer_length_reg) > 32'(MAX_KMER)) begin
            k_eff = RUN_MAX;
        end else begin
            k_eff = RUN_W'(kmer_length_reg);
        end
    end

    // Mask covering the low 2k bits of the key
    assign key_bits = 7'(k_eff) << 1;
    always_comb begin
        for (int i = 0; i < KEY_W; i++) begin
            key_mask[i] = (7'(i) < key_bits);
        end
    end

    assign lookup       = kwh_pkg::lookup_base(base_char);
    assign restart_char = (base_char == kwh_pkg::CHAR_J) || (base_char == kwh_pkg::CHAR_X)
                       || (base_char == kwh_pkg::CHAR_N);

    // New sequence clears window and position before this base is taken in
    assign key_base = fresh ? '0 : rolling_key_reg;
    assign run_base = fresh ? '0 : usable_run_reg;
    assign pos      = fresh ? 32'd0 : base_index_reg;

    // Next state and result
    always_comb begin
        rolling_key_next  = rolling_key_reg;
        usable_run_next   = usable_run_reg;
        base_index_next   = base_index_reg;
        m_valid_next      = m_valid_reg & ~m_tready;
        window_start_next = window_start_reg;
        kmer_key_next     = kmer_key_reg;
        bad_base_next     = bad_base_reg;

        if (accept) begin
            base_index_next = pos + 32'd1;
            if (restart_char) begin
                rolling_key_next = '0;
                usable_run_next  = '0;
            end else if (!lookup.known) begin
                // Unrecognized character: flag it at its own position
                rolling_key_next  = '0;
                usable_run_next   = '0;
                m_valid_next      = 1'b1;
                window_start_next = pos;
                kmer_key_next     = 64'd0;
                bad_base_next     = 1'b1;
            end else begin
                rolling_key_next = (key_base << 2) | KEY_W'(lookup.code);
                usable_run_next  = (run_base < RUN_MAX) ? run_base + RUN_W'(1) : run_base;
                if (usable_run_next >= k_eff) begin
                    m_valid_next      = 1'b1;
                    window_start_next = pos - (32'(k_eff) - 32'd1);
                    kmer_key_next     = 64'(rolling_key_next & key_mask);
                    bad_base_next     = 1'b0;
                end
            end
        end
    end

    // Registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kmer_length_reg <= kwh_pkg::KMER_LENGTH_RESET;
            rolling_key_reg <= '0;
            usable_run_reg  <= '0;
            base_index_reg  <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid) begin
                kmer_length_reg <= cfg_data;
            end
            rolling_key_reg <= rolling_key_next;
            usable_run_reg  <= usable_run_next;
            base_index_reg  <= base_index_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge aclk) begin
        window_start_reg <= window_start_next;
        kmer_key_reg     <= kmer_key_next;
        bad_base_reg     <= bad_base_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {kmer_key_reg, window_start_reg};
    assign m_tuser  = bad_base_reg;

endmodule
